@@ design/bsnr_pkg.sv @@
// bsnr_pkg: shared types, constants and gain table for the baseline snr grouper
// used by baseline_snr_grouper; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package bsnr_pkg;

  // baseline and fixed point constants
  localparam int MAX_BASELINE  = 1024;
  localparam int MEAN_FRAC     = 8;
  localparam int GROUP_MAX     = 16;
  localparam int GROUP_RESET   = 4;

  // divider shift width and iteration counts
  localparam int DIV_BITS      = 84;
  localparam int MEAN_STEPS    = 35;
  localparam int VAR_STEPS     = 84;
  localparam int SNR_STEPS     = 64;
  localparam int ROOT_STEPS    = 32;

  typedef struct packed {
    logic        command;
    logic [15:0] sample;
    logic        trace_end;
  } item_t;

  typedef struct packed {
    logic signed [31:0] snr_value;
    logic [15:0]        center_index;
    logic               saturated;
    logic               final_group;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE,
    ST_N2,
    ST_BB,
    ST_ALO,
    ST_AHI,
    ST_MEAN_DIV,
    ST_VAR_DIV,
    ST_ROOT,
    ST_ACC,
    ST_SNR_MUL,
    ST_SNR_DIV,
    ST_EMIT
  } state_t;

  // floor(sqrt(n) * 2^16) for group sizes 1 to 16
  function automatic logic [18:0] sqrt_gain(input logic [4:0] n);
    logic [18:0] g;
    case (n)
      5'd1:    g = 19'd65536;
      5'd2:    g = 19'd92681;
      5'd3:    g = 19'd113511;
      5'd4:    g = 19'd131072;
      5'd5:    g = 19'd146542;
      5'd6:    g = 19'd160529;
      5'd7:    g = 19'd173391;
      5'd8:    g = 19'd185363;
      5'd9:    g = 19'd196608;
      5'd10:   g = 19'd207243;
      5'd11:   g = 19'd217358;
      5'd12:   g = 19'd227023;
      5'd13:   g = 19'd236293;
      5'd14:   g = 19'd245213;
      5'd15:   g = 19'd253819;
      5'd16:   g = 19'd262144;
      default: g = 19'd0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

@@ design/baseline_snr_grouper.sv @@
// baseline_snr_grouper: baseline rms and grouped snr over one digitizer trace
// depends on bsnr_pkg (types, state codes, gain table)
`timescale 1ns / 1ps
`default_nettype none

// Takes one sample transaction at a time; item_stall is high while a sample is
// worked on. A baseline sample passes through ST_BASE, and a trace sample that
// does not close a group through ST_ACC. The first trace sample of a trace also
// computes the baseline mean and rms: multiplies in ST_N2, ST_BB, ST_ALO and
// ST_AHI on the shared 32x32 multiplier, then mean division, variance division
// and square root on the shared one-bit-per-cycle divide/root unit (ST_N2 goes
// straight to ST_ACC when no baseline was seen). A sample that closes a group
// adds a multiply, a division (skipped when the result saturates) and the load
// of the result register, which then holds the result until it is taken.
module baseline_snr_grouper (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  bsnr_pkg::item_t  item,
  output logic             result_valid,
  input  logic             result_stall,
  output bsnr_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [4:0]       cfg_data
);
  import bsnr_pkg::*;

  state_t state, state_next;

  logic [4:0]         group_size;
  logic [15:0]        samp;
  logic               trace_end;
  logic               fin;

  logic [25:0]        base_sum;
  logic [41:0]        base_sq;
  logic [10:0]        base_cnt;
  logic [23:0]        base_mean;
  logic [31:0]        scale;
  logic               stats_ready;
  logic signed [31:0] acc;
  logic [4:0]         fill;
  logic [15:0]        pos;

  logic [20:0]        n_sq;
  logic [51:0]        b_sq;
  logic [51:0]        a_prod;

  // shared divide / root unit
  logic [DIV_BITS-1:0] dv_dnd;
  logic [31:0]         dv_dsr;
  logic [31:0]         dv_rem;
  logic [63:0]         dv_quo;
  logic [33:0]         sq_rem;
  logic [6:0]          cnt;
  logic [31:0]         res_q;
  logic                res_sat;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic [32:0] dv_sh, dv_diff;
  logic        dv_ge;
  logic [31:0] dv_rem_step;
  logic [35:0] sq_sh, sq_try, sq_diff;
  logic        sq_ge;
  logic [33:0] sq_rem_step;

  logic [31:0] mag;
  logic [63:0] lim;
  logic [51:0] var_d;
  logic [34:0] mean_dnd;
  logic [4:0]  gs_eff;
  logic [4:0]  fill_inc;
  logic        base_open;
  logic        out_free;
  logic        in_take;

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // one restoring divide step
  assign dv_sh       = {dv_rem, dv_dnd[DIV_BITS-1]};
  assign dv_diff     = dv_sh - {1'b0, dv_dsr};
  assign dv_ge       = dv_sh >= {1'b0, dv_dsr};
  assign dv_rem_step = dv_ge ? dv_diff[31:0] : dv_sh[31:0];

  // one square root digit step, root kept in dv_quo
  assign sq_sh       = {sq_rem, dv_dnd[DIV_BITS-1:DIV_BITS-2]};
  assign sq_try      = {2'b00, dv_quo[31:0], 2'b01};
  assign sq_diff     = sq_sh - sq_try;
  assign sq_ge       = sq_sh >= sq_try;
  assign sq_rem_step = sq_ge ? sq_diff[33:0] : sq_sh[33:0];

  // group magnitude and clip limit
  assign mag = acc[31] ? 32'(32'd0 - $unsigned(acc)) : $unsigned(acc);
  assign lim = acc[31] ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;

  assign var_d    = (a_prod > b_sq) ? (a_prod - b_sq) : 52'd0;
  assign mean_dnd = 35'({base_sum, 8'd0}) + 35'(base_cnt[10:1]);

  assign gs_eff = (group_size == 5'd0) ? 5'd1 :
                  (group_size > 5'(GROUP_MAX)) ? 5'(GROUP_MAX) : group_size;
  assign fill_inc  = fill + 5'd1;
  assign base_open = !stats_ready && (base_cnt < 11'(MAX_BASELINE));
  assign out_free  = !result_valid || !result_stall;
  assign in_take   = item_valid && !item_stall;

  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (!item.command) state_next = ST_BASE;
          else if (stats_ready) state_next = ST_ACC;
          else state_next = ST_N2;
        end
      end
      ST_BASE: begin
        if (trace_end && stats_ready && fill != 5'd0) state_next = ST_SNR_MUL;
        else state_next = ST_IDLE;
      end
      ST_N2:       state_next = (base_cnt == 11'd0) ? ST_ACC : ST_BB;
      ST_BB:       state_next = ST_ALO;
      ST_ALO:      state_next = ST_AHI;
      ST_AHI:      state_next = ST_MEAN_DIV;
      ST_MEAN_DIV: if (cnt == 7'd0) state_next = ST_VAR_DIV;
      ST_VAR_DIV:  if (cnt == 7'd0) state_next = ST_ROOT;
      ST_ROOT:     if (cnt == 7'd0) state_next = ST_ACC;
      ST_ACC: begin
        if (trace_end || fill_inc >= gs_eff) state_next = ST_SNR_MUL;
        else state_next = ST_IDLE;
      end
      ST_SNR_MUL: begin
        if (scale == 32'd0 || mul_p[63:56] != 8'd0) state_next = ST_EMIT;
        else state_next = ST_SNR_DIV;
      end
      ST_SNR_DIV:  if (cnt == 7'd0) state_next = ST_EMIT;
      ST_EMIT:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // handshake and multiplier operand select
  always_comb begin
    item_stall = (state != ST_IDLE);
    mul_a      = 32'd0;
    mul_b      = 32'd0;
    case (state)
      ST_BASE: begin
        mul_a = 32'(samp);
        mul_b = 32'(samp);
      end
      ST_N2: begin
        mul_a = 32'(base_cnt);
        mul_b = 32'(base_cnt);
      end
      ST_BB: begin
        mul_a = 32'(base_sum);
        mul_b = 32'(base_sum);
      end
      ST_ALO: begin
        mul_a = 32'(base_cnt);
        mul_b = 32'(base_sq[20:0]);
      end
      ST_AHI: begin
        mul_a = 32'(base_cnt);
        mul_b = 32'(base_sq[41:21]);
      end
      ST_SNR_MUL: begin
        mul_a = mag;
        mul_b = 32'(sqrt_gain(fill));
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // state and configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      group_size <= 5'(GROUP_RESET);
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) group_size <= cfg_data;
    end
  end

  // trace statistics and group state
  always_ff @(posedge clk) begin
    if (rst) begin
      base_sum    <= '0;
      base_sq     <= '0;
      base_cnt    <= '0;
      base_mean   <= '0;
      scale       <= '0;
      stats_ready <= 1'b0;
      acc         <= '0;
      fill        <= '0;
      pos         <= '0;
      fin         <= 1'b0;
    end else begin
      case (state)
        ST_BASE: begin
          if (base_open) begin
            base_sum <= base_sum + 26'(samp);
            base_sq  <= base_sq + 42'(mul_p[31:0]);
            base_cnt <= base_cnt + 11'd1;
          end
          if (trace_end) begin
            if (stats_ready && fill != 5'd0) begin
              fin <= 1'b1;
            end else begin
              base_sum    <= '0;
              base_sq     <= '0;
              base_cnt    <= '0;
              base_mean   <= '0;
              scale       <= '0;
              stats_ready <= 1'b0;
              acc         <= '0;
              fill        <= '0;
              pos         <= '0;
            end
          end
        end
        ST_N2: begin
          if (base_cnt == 11'd0) begin
            base_mean   <= '0;
            scale       <= '0;
            stats_ready <= 1'b1;
          end
        end
        ST_MEAN_DIV: if (cnt == 7'd0) base_mean <= dv_quo[23:0];
        ST_ROOT: begin
          if (cnt == 7'd0) begin
            scale       <= dv_quo[31:0];
            stats_ready <= 1'b1;
          end
        end
        ST_ACC: begin
          acc  <= acc + $signed({8'd0, samp, 8'd0}) - $signed({8'd0, base_mean});
          fill <= fill_inc;
          pos  <= pos + 16'd1;
          fin  <= trace_end;
        end
        ST_EMIT: begin
          if (out_free) begin
            acc  <= '0;
            fill <= '0;
            if (fin) begin
              base_sum    <= '0;
              base_sq     <= '0;
              base_cnt    <= '0;
              base_mean   <= '0;
              scale       <= '0;
              stats_ready <= 1'b0;
              pos         <= '0;
            end
          end
        end
        default: begin
          stats_ready <= stats_ready;
        end
      endcase
    end
  end

  // sample latch, multiply results and divide / root unit
  always_ff @(posedge clk) begin
    if (in_take) begin
      samp      <= item.sample;
      trace_end <= item.trace_end;
    end
    case (state)
      ST_N2:  n_sq   <= mul_p[20:0];
      ST_BB:  b_sq   <= mul_p[51:0];
      ST_ALO: a_prod <= mul_p[51:0];
      ST_AHI: begin
        a_prod <= a_prod + {mul_p[30:0], 21'd0};
        dv_dnd <= {mean_dnd, 49'd0};
        dv_dsr <= 32'(base_cnt);
        dv_rem <= '0;
        dv_quo <= '0;
        cnt    <= 7'(MEAN_STEPS);
      end
      ST_MEAN_DIV: begin
        if (cnt != 7'd0) begin
          dv_dnd <= dv_dnd << 1;
          dv_rem <= dv_rem_step;
          dv_quo <= {dv_quo[62:0], dv_ge};
          cnt    <= cnt - 7'd1;
        end else begin
          dv_dnd <= {var_d, 32'd0};
          dv_dsr <= 32'(n_sq);
          dv_rem <= '0;
          dv_quo <= '0;
          cnt    <= 7'(VAR_STEPS);
        end
      end
      ST_VAR_DIV: begin
        if (cnt != 7'd0) begin
          dv_dnd <= dv_dnd << 1;
          dv_rem <= dv_rem_step;
          dv_quo <= {dv_quo[62:0], dv_ge};
          cnt    <= cnt - 7'd1;
        end else begin
          dv_dnd <= {dv_quo, 20'd0};
          sq_rem <= '0;
          dv_quo <= '0;
          cnt    <= 7'(ROOT_STEPS);
        end
      end
      ST_ROOT: begin
        if (cnt != 7'd0) begin
          dv_dnd <= dv_dnd << 2;
          sq_rem <= sq_rem_step;
          dv_quo <= {dv_quo[62:0], sq_ge};
          cnt    <= cnt - 7'd1;
        end
      end
      ST_SNR_MUL: begin
        if (scale == 32'd0) begin
          res_q   <= (mag == 32'd0) ? 32'd0 : lim[31:0];
          res_sat <= 1'b1;
        end else if (mul_p[63:56] != 8'd0) begin
          res_q   <= lim[31:0];
          res_sat <= 1'b1;
        end else begin
          dv_dnd <= {mul_p, 20'd0};
          dv_dsr <= scale;
          dv_rem <= '0;
          dv_quo <= '0;
          cnt    <= 7'(SNR_STEPS);
        end
      end
      ST_SNR_DIV: begin
        if (cnt != 7'd0) begin
          dv_dnd <= dv_dnd << 1;
          dv_rem <= dv_rem_step;
          dv_quo <= {dv_quo[62:0], dv_ge};
          cnt    <= cnt - 7'd1;
        end else if (dv_quo > lim) begin
          res_q   <= lim[31:0];
          res_sat <= 1'b1;
        end else begin
          res_q   <= dv_quo[31:0];
          res_sat <= 1'b0;
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      result.snr_value    <= acc[31] ? $signed(32'd0 - res_q) : $signed(res_q);
      result.center_index <= 16'(pos - 16'(fill) + 16'(fill[4:1]));
      result.saturated    <= res_sat;
      result.final_group  <= fin;
    end
  end

  // a sample transaction always leaves the block busy in the cycle after it is taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> item_stall)
    else $error("block took a sample without going busy");

  // a group never holds more than the largest group size
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 5'(GROUP_MAX))
    else $error("group fill above the largest group size");

  // no trace sample is grouped before the baseline statistics are latched
  a_fill_needs_stats: assert property (@(posedge clk) disable iff (rst)
    !stats_ready |-> fill == 5'd0)
    else $error("group pending without baseline statistics");

endmodule

`default_nettype wire
